FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both macros expect clk and arst_n to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

FILE: hw/rtl/vryp_pkg.sv
`default_nettype none

package vryp_pkg;

	// Fixed point formats.
	localparam int ANGLE_FRAC_BITS = 14;
	localparam int COORD_FRAC_BITS_DEF = 8;

	// Rotated coordinate, shifted depth and numerator widths.
	localparam int ROT_W = 19;
	localparam int ZC_W = 20;
	localparam int NUM_W = 36;

	// Quotient magnitude bits before saturation.
	localparam int QUO_W = 17;

	// Depths of the queue between the front and divider parts and of the result queue.
	localparam int MIDQ_DEPTH = 8;
	localparam int OUTQ_DEPTH = 32;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_COS = 3'd0;
	localparam logic [2:0] REG_SIN = 3'd1;
	localparam logic [2:0] REG_ZOFF = 3'd2;
	localparam logic [2:0] REG_WIDTH = 3'd3;
	localparam logic [2:0] REG_HEIGHT = 3'd4;

	// Word handed from the front part to the divider part.
	typedef struct packed {
		logic behind;
		logic [ZC_W-2:0] zc;
		logic signed [NUM_W-1:0] nx;
		logic signed [NUM_W-1:0] ny;
	} front_word_t;

	// One finished result word.
	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic behind_eye;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vryp_fifo.sv
`default_nettype none

module vryp_fifo import vryp_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic pop,
	output logic [WIDTH-1:0] dout,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW:0] wr_ptr_q;
	logic [AW:0] rd_ptr_q;

	// Pointers carry one extra bit to tell full from empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	// Storage is written at the write pointer.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q[AW-1:0]] <= din;
	end

	assign dout = slot_q[rd_ptr_q[AW-1:0]];
	assign empty = (wr_ptr_q == rd_ptr_q);

endmodule

`default_nettype wire

FILE: hw/rtl/vryp_front.sv
`default_nettype none

module vryp_front import vryp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic signed [15:0] vx,
	input  wire logic signed [15:0] vy,
	input  wire logic signed [15:0] vz,
	input  wire logic signed [15:0] cos_angle,
	input  wire logic signed [15:0] sin_angle,
	input  wire logic [14:0] z_offset,
	input  wire logic [12:0] screen_width,
	input  wire logic [12:0] screen_height,
	output logic out_valid,
	output front_word_t out_word
);

	logic valid_s1, valid_s2, valid_s3;
	logic signed [31:0] pxc_s1, pzs_s1, pzc_s1, pxs_s1;
	logic signed [15:0] vy_s1, vy_s2;
	logic signed [ROT_W-1:0] xr_s2;
	logic signed [ZC_W-1:0] zc_s2;
	logic behind_s2;
	front_word_t word_s3;

	logic signed [32:0] xsum, zsum;
	logic signed [ZC_W-1:0] zc_n;
	logic signed [13:0] ws, hs;
	logic signed [ZC_W:0] dy;
	logic signed [NUM_W-1:0] nx_n, ny_n;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: the four rotation products.
	always_ff @(posedge clk) begin
		pxc_s1 <= vx * cos_angle;
		pzs_s1 <= vz * sin_angle;
		pzc_s1 <= vz * cos_angle;
		pxs_s1 <= vx * sin_angle;
		vy_s1 <= vy;
	end

	// Stage 2: floor shift of the sums, camera offset and the behind test.
	assign xsum = 33'(pxc_s1) + 33'(pzs_s1);
	assign zsum = 33'(pzc_s1) - 33'(pxs_s1);
	assign zc_n = ZC_W'($signed(zsum[32:ANGLE_FRAC_BITS]))
		+ $signed({5'b0, z_offset});

	always_ff @(posedge clk) begin
		xr_s2 <= xsum[32:ANGLE_FRAC_BITS];
		zc_s2 <= zc_n;
		behind_s2 <= zc_n[ZC_W-1] || (zc_n == '0);
		vy_s2 <= vy_s1;
	end

	// Stage 3: projection numerators.
	assign ws = $signed({1'b0, screen_width});
	assign hs = $signed({1'b0, screen_height});
	assign dy = (ZC_W+1)'(zc_s2) - (ZC_W+1)'(vy_s2);
	assign nx_n = xr_s2 * hs + zc_s2 * ws;
	assign ny_n = dy * hs;

	always_ff @(posedge clk) begin
		word_s3.behind <= behind_s2;
		word_s3.zc <= zc_s2[ZC_W-2:0];
		word_s3.nx <= nx_n;
		word_s3.ny <= ny_n;
	end

	assign out_valid = valid_s3;
	assign out_word = word_s3;

endmodule

`default_nettype wire

FILE: hw/rtl/vryp_back.sv
`default_nettype none

module vryp_back import vryp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire front_word_t in_word,
	output logic out_valid,
	output result_t out_res
);

	localparam int REM_W = NUM_W;
	localparam int DEN_W = ZC_W;
	localparam int CMP_W = DEN_W + QUO_W + 1;

	// Stage 0 is the sign split, stages 1 to QUO_W take one quotient bit each.
	logic valid_s [QUO_W+1];
	logic [REM_W-1:0] remx_s [QUO_W+1];
	logic [REM_W-1:0] remy_s [QUO_W+1];
	logic [QUO_W-1:0] qx_s [QUO_W+1];
	logic [QUO_W-1:0] qy_s [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic negx_s [QUO_W+1];
	logic negy_s [QUO_W+1];
	logic ovfx_s [QUO_W+1];
	logic ovfy_s [QUO_W+1];
	logic behind_s [QUO_W+1];

	logic [REM_W-1:0] magx, magy;
	logic [DEN_W-1:0] den_n;
	logic [CMP_W-1:0] den_top;
	logic valid_q;
	result_t res_q;
	logic [15:0] sx_n, sy_n;

	// Stage 0: magnitudes, doubled depth and the overflow check.
	assign magx = in_word.nx[NUM_W-1] ? REM_W'(-in_word.nx) : REM_W'(in_word.nx);
	assign magy = in_word.ny[NUM_W-1] ? REM_W'(-in_word.ny) : REM_W'(in_word.ny);
	assign den_n = {in_word.zc, 1'b0};
	assign den_top = {1'b0, den_n, {QUO_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s[0] <= 1'b0;
		else valid_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		remx_s[0] <= magx;
		remy_s[0] <= magy;
		qx_s[0] <= '0;
		qy_s[0] <= '0;
		den_s[0] <= den_n;
		negx_s[0] <= in_word.nx[NUM_W-1];
		negy_s[0] <= in_word.ny[NUM_W-1];
		ovfx_s[0] <= CMP_W'(magx) >= den_top;
		ovfy_s[0] <= CMP_W'(magy) >= den_top;
		behind_s[0] <= in_word.behind;
	end

	// Restoring division steps, most significant quotient bit first.
	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		localparam int SH = QUO_W - 1 - i;
		logic [CMP_W-1:0] dsh, rx, ry;
		logic gex, gey;

		assign dsh = CMP_W'(den_s[i]) << SH;
		assign rx = CMP_W'(remx_s[i]);
		assign ry = CMP_W'(remy_s[i]);
		assign gex = rx >= dsh;
		assign gey = ry >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[i+1] <= 1'b0;
			else valid_s[i+1] <= valid_s[i];
		end

		always_ff @(posedge clk) begin
			remx_s[i+1] <= gex ? REM_W'(rx - dsh) : remx_s[i];
			remy_s[i+1] <= gey ? REM_W'(ry - dsh) : remy_s[i];
			qx_s[i+1] <= qx_s[i] | (QUO_W'(gex) << SH);
			qy_s[i+1] <= qy_s[i] | (QUO_W'(gey) << SH);
			den_s[i+1] <= den_s[i];
			negx_s[i+1] <= negx_s[i];
			negy_s[i+1] <= negy_s[i];
			ovfx_s[i+1] <= ovfx_s[i];
			ovfy_s[i+1] <= ovfy_s[i];
			behind_s[i+1] <= behind_s[i];
		end
	end

	// Sign restore and saturation to 16 bits.
	function automatic logic [15:0] sat_quo(input logic neg, input logic ovf,
		input logic [QUO_W-1:0] q);
		logic [15:0] r;
		if (neg) begin
			if (ovf || q > QUO_W'(32768)) r = 16'h8000;
			else r = 16'(-q);
		end else begin
			if (ovf || q > QUO_W'(32767)) r = 16'h7fff;
			else r = q[15:0];
		end
		return r;
	endfunction

	assign sx_n = sat_quo(negx_s[QUO_W], ovfx_s[QUO_W], qx_s[QUO_W]);
	assign sy_n = sat_quo(negy_s[QUO_W], ovfy_s[QUO_W], qy_s[QUO_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= valid_s[QUO_W];
	end

	always_ff @(posedge clk) begin
		res_q.behind_eye <= behind_s[QUO_W];
		res_q.screen_x <= behind_s[QUO_W] ? 16'sd0 : $signed(sx_n);
		res_q.screen_y <= behind_s[QUO_W] ? 16'sd0 : $signed(sy_n);
	end

	assign out_valid = valid_q;
	assign out_res = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/vertex_rotate_y_project.sv
// Rotates Q8.8 vertices about the Y axis and projects them to screen pixels.
// Input words enter on vx, vy, vz with push; a word is taken at a clock edge
// where push is high and full is low. Results leave on screen_x, screen_y and
// behind_eye; the oldest result is shown while empty is low and is removed by
// pop. Rotation angle, camera distance and viewport size sit in five 32-bit
// APB registers at byte addresses 0, 4, 8, 12 and 16; write them while idle.
// An accepted word passes the front stages (rotation products; shift, camera
// offset and behind test; projection numerators), the front queue, one sign
// stage, seventeen division steps (one quotient bit per stage, x and y in
// parallel), the saturation stage and the result queue.
// Throughput is one word per cycle while results are taken. When the
// receiver stalls, results collect in a 32-word queue; push is refused only
// once every slot is spoken for, and accepted words are never dropped.
// Reset clears both queues and loads cos 1.0, sin 0, a camera distance of 15
// and a 640 by 480 viewport.
`default_nettype none
`include "assert_macros.svh"

module vertex_rotate_y_project import vryp_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  wire logic push,
	output logic full,
	input  wire logic signed [15:0] vx,
	input  wire logic signed [15:0] vy,
	input  wire logic signed [15:0] vz,
	output logic empty,
	input  wire logic pop,
	output logic signed [15:0] screen_x,
	output logic signed [15:0] screen_y,
	output logic behind_eye
);

	localparam int ZOFF_RAW = 15 << COORD_FRAC_BITS;
	localparam int ZOFF_RST = (ZOFF_RAW > 32767) ? 32767 : ZOFF_RAW;
	localparam int FC_W = $clog2(MIDQ_DEPTH + 1);
	localparam int BC_W = $clog2(OUTQ_DEPTH + 1);

	logic signed [15:0] cos_q, sin_q;
	logic [14:0] zoff_q;
	logic [12:0] width_q, height_q;
	logic [2:0] reg_idx;
	logic cfg_wr;

	logic in_acc, out_acc;
	logic front_valid, midq_empty, midq_pop, back_valid;
	front_word_t front_word, midq_word;
	result_t back_res, outq_res;
	logic [FC_W-1:0] fcred_q;
	logic [BC_W-1:0] bcred_q;

	// Register file write.
	assign reg_idx = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= 16'sd16384;
			sin_q <= 16'sd0;
			zoff_q <= 15'(ZOFF_RST);
			width_q <= 13'd640;
			height_q <= 13'd480;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_COS: cos_q <= $signed(pwdata[15:0]);
				REG_SIN: sin_q <= $signed(pwdata[15:0]);
				REG_ZOFF: zoff_q <= pwdata[14:0];
				REG_WIDTH: width_q <= pwdata[12:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// Register read.
	always_comb begin
		unique case (reg_idx)
			REG_COS: prdata = {16'b0, cos_q};
			REG_SIN: prdata = {16'b0, sin_q};
			REG_ZOFF: prdata = {17'b0, zoff_q};
			REG_WIDTH: prdata = {19'b0, width_q};
			REG_HEIGHT: prdata = {19'b0, height_q};
			default: prdata = '0;
		endcase
	end

	// Credits: the front counts words up to the front queue's depth, the back
	// counts words up to the result queue's depth.
	assign full = (fcred_q == FC_W'(MIDQ_DEPTH));
	assign in_acc = push && !full;
	assign out_acc = pop && !empty;
	assign midq_pop = !midq_empty && (bcred_q < BC_W'(OUTQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcred_q <= '0;
			bcred_q <= '0;
		end else begin
			fcred_q <= fcred_q + FC_W'(in_acc) - FC_W'(midq_pop);
			bcred_q <= bcred_q + BC_W'(midq_pop) - BC_W'(out_acc);
		end
	end

	// Front part: rotation, depth offset and numerators.
	vryp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_acc),
		.vx(vx),
		.vy(vy),
		.vz(vz),
		.cos_angle(cos_q),
		.sin_angle(sin_q),
		.z_offset(zoff_q),
		.screen_width(width_q),
		.screen_height(height_q),
		.out_valid(front_valid),
		.out_word(front_word)
	);

	// Queue between the front and the divider.
	vryp_fifo #(
		.WIDTH($bits(front_word_t)),
		.DEPTH(MIDQ_DEPTH)
	) u_midq (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_valid),
		.din(front_word),
		.pop(midq_pop),
		.dout(midq_word),
		.empty(midq_empty)
	);

	// Back part: pipelined division and saturation.
	vryp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(midq_pop),
		.in_word(midq_word),
		.out_valid(back_valid),
		.out_res(back_res)
	);

	// Result queue.
	vryp_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(back_valid),
		.din(back_res),
		.pop(out_acc),
		.dout(outq_res),
		.empty(empty)
	);

	assign screen_x = outq_res.screen_x;
	assign screen_y = outq_res.screen_y;
	assign behind_eye = outq_res.behind_eye;

	// Credit counters never pass the queue depths.
	`ASSERT_NEVER(a_fcred_bound, fcred_q > FC_W'(MIDQ_DEPTH), "front credit overrun")
	`ASSERT_NEVER(a_bcred_bound, bcred_q > BC_W'(OUTQ_DEPTH), "back credit overrun")
	// A word behind the eye carries zero coordinates.
	`ASSERT_IMPL(a_behind_zero, !empty && behind_eye, {screen_x, screen_y} == '0, "behind nonzero")
	// The divider takes a word only from a filled queue.
	`ASSERT_IMPL(a_midq_pop, midq_pop, !midq_empty && fcred_q != '0, "pop from empty front queue")

endmodule

`default_nettype wire
